>>> rtl/core/sld_pkg.sv
// shared types and constants for the sync/length/xor frame deframer
package sld_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned CFG_ADDR_W   = 3;

    localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd138;
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd6;
    localparam logic [BYTE_W-1:0] LEN_LO_INDEX  = 8'd4;
    localparam logic [BYTE_W-1:0] LEN_HI_INDEX  = 8'd5;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_0  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_1  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VER_2   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VER_3   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEN = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PROGRESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_BODY
    } phase_t;

endpackage

>>> rtl/core/sync_length_xor_frame_deframer.sv
// top level of the sync/length/xor frame deframer
// Byte-stream deframer. Each received word is one byte; the block hunts for the
// four configured header bytes, reads a little-endian length from frame bytes 4
// and 5 (frame length is that value plus 2, at least 6) and passes on every frame
// byte from index 4 onward with its index. The final byte carries last and a
// status: good when the xor of all bytes but the trailing two equals the trailing
// little-endian word, bad otherwise; a frame longer than max_frame_length ends at
// byte 5 with the too-long status. Header bytes give no output word. Throughput
// is one byte per clock while the receiver takes words. A byte that is taken
// sits in the input register until it is processed; its word then enters the
// result register, from which the receiver sees it. All matching, xor and
// length checks are combinational between the input and result registers.
// Every byte, header bytes included, waits in the input register while the
// result register holds a word the receiver has not taken yet.
// Configuration writes take effect at once and are meant for idle periods.
module sync_length_xor_frame_deframer
    import sld_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_W-1:0]     cfg_wdata,
    // received byte stream
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_in_byte,
    // frame words out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_frame_byte,
    output logic [BYTE_W-1:0]     m_byte_index,
    output logic                  m_last,
    output logic [STATUS_W-1:0]   m_status
);

    // configuration registers
    logic [BYTE_W-1:0] sync0_reg, sync1_reg, ver2_reg, ver3_reg, max_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync0_reg   <= '0;
            sync1_reg   <= '0;
            ver2_reg    <= '0;
            ver3_reg    <= '0;
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SYNC_0:  sync0_reg   <= cfg_wdata;
                REG_SYNC_1:  sync1_reg   <= cfg_wdata;
                REG_VER_2:   ver2_reg    <= cfg_wdata;
                REG_VER_3:   ver3_reg    <= cfg_wdata;
                REG_MAX_LEN: max_len_reg <= cfg_wdata;
                default: ;   // writes to unused indexes are dropped
            endcase
        end
    end

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, out_index_reg;
    logic              out_last_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // parse state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] len_lo_reg, len_lo_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] chk_reg, chk_next;

    // result of the byte being processed
    logic                res_valid;
    logic                res_last;
    logic [STATUS_W-1:0] res_status;

    // handshake: a byte is processed when the result register can take a word
    logic out_free;
    logic advance;
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // per-byte parse logic
    logic              do_hunt;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] hdr_byte;
    logic [BYTE_W:0]   total;       // length word plus 2, high byte zero
    logic [BYTE_W-1:0] len_eff, xor_eff, chk_eff;
    logic [BYTE_W:0]   idx_p1, idx_p2;
    logic              aborted;

    assign b      = in_byte_reg;
    assign idx_p1 = {1'b0, count_reg} + 9'd1;
    assign idx_p2 = {1'b0, count_reg} + 9'd2;

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        len_lo_next = len_lo_reg;
        xor_next    = xor_reg;
        chk_next    = chk_reg;
        res_valid   = 1'b0;
        res_last    = 1'b0;
        res_status  = ST_PROGRESS;
        do_hunt     = 1'b0;
        aborted     = 1'b0;
        hdr_byte    = ver3_reg;
        total       = '0;
        len_eff     = len_reg;
        xor_eff     = xor_reg;
        chk_eff     = chk_reg;

        unique case (phase_reg)
            PH_HDR1, PH_HDR2, PH_HDR3: begin
                unique case (phase_reg)
                    PH_HDR1: hdr_byte = sync1_reg;
                    PH_HDR2: hdr_byte = ver2_reg;
                    default: hdr_byte = ver3_reg;
                endcase
                if (b == hdr_byte) begin
                    xor_next   = xor_reg ^ b;
                    count_next = count_reg + 8'd1;
                    unique case (phase_reg)
                        PH_HDR1: phase_next = PH_HDR2;
                        PH_HDR2: phase_next = PH_HDR3;
                        default: begin
                            phase_next = PH_BODY;
                            len_next   = MIN_FRAME_LEN;
                        end
                    endcase
                end else begin
                    do_hunt = 1'b1;   // mismatch: retry this byte as sync byte 0
                end
            end
            PH_BODY: begin
                res_valid = 1'b1;
                if (count_reg == LEN_LO_INDEX) begin
                    len_lo_next = b;
                    count_next  = LEN_HI_INDEX;
                end else begin
                    if (count_reg == LEN_HI_INDEX) begin
                        total = {1'b0, len_lo_reg} + 9'd2;
                        if (total < {1'b0, MIN_FRAME_LEN}) begin
                            total = {1'b0, MIN_FRAME_LEN};
                        end
                        // nonzero high length byte always exceeds the 8-bit limit
                        if (b != '0 || total > {1'b0, max_len_reg}) begin
                            aborted = 1'b1;
                        end else begin
                            len_eff = total[BYTE_W-1:0];
                            // fold length low byte into the check
                            if ({1'b0, LEN_HI_INDEX} + 9'd1 < {1'b0, len_eff}) begin
                                xor_eff = xor_reg ^ len_lo_reg;
                            end else if ({1'b0, LEN_HI_INDEX} + 9'd1 == {1'b0, len_eff}) begin
                                chk_eff = len_lo_reg;
                            end
                        end
                    end
                    if (aborted) begin
                        res_last   = 1'b1;
                        res_status = ST_TOO_LONG;
                        phase_next = PH_IDLE;
                        count_next = '0;
                        len_next   = '0;
                        len_lo_next = '0;
                        xor_next   = '0;
                        chk_next   = '0;
                    end else if (idx_p1 >= {1'b0, len_eff}) begin
                        res_last   = 1'b1;
                        res_status = (xor_eff == chk_eff && b == '0) ? ST_GOOD : ST_BAD;
                        phase_next = PH_IDLE;
                        count_next = '0;
                        len_next   = '0;
                        len_lo_next = '0;
                        xor_next   = '0;
                        chk_next   = '0;
                    end else begin
                        len_next   = len_eff;
                        xor_next   = xor_eff;
                        chk_next   = chk_eff;
                        if (idx_p2 < {1'b0, len_eff}) begin
                            xor_next = xor_eff ^ b;
                        end else if (idx_p2 == {1'b0, len_eff}) begin
                            chk_next = b;
                        end
                        count_next = idx_p1[BYTE_W-1:0];
                    end
                end
            end
            default: begin
                do_hunt = 1'b1;
            end
        endcase

        // restart the hunt with this byte as candidate sync byte 0
        if (do_hunt) begin
            len_next    = '0;
            len_lo_next = '0;
            chk_next    = '0;
            if (b == sync0_reg) begin
                phase_next = PH_HDR1;
                count_next = 8'd1;
                xor_next   = b;
            end else begin
                phase_next = PH_IDLE;
                count_next = '0;
                xor_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            len_reg    <= '0;
            len_lo_reg <= '0;
            xor_reg    <= '0;
            chk_reg    <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            len_lo_reg <= len_lo_next;
            xor_reg    <= xor_next;
            chk_reg    <= chk_next;
        end
    end

    // result register
    logic load_out;
    assign load_out = advance && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= load_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_byte_reg   <= b;
            out_index_reg  <= count_reg;
            out_last_reg   <= res_last;
            out_status_reg <= res_status;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_byte_reg;
    assign m_byte_index = out_index_reg;
    assign m_last       = out_last_reg;
    assign m_status     = out_status_reg;

    // checks

    // status stays zero on words that do not close a frame
    a_status_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == ST_PROGRESS))
        else $error("status set on a word that is not last");

    // only body bytes are passed on
    a_index_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_index >= LEN_LO_INDEX))
        else $error("header byte passed on");

    // body phase always counts from index 4 upward
    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (count_reg >= LEN_LO_INDEX))
        else $error("byte count below body start in body phase");

    // a word that closes a frame leaves the parser hunting
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && res_last) |=> (phase_reg == PH_IDLE && count_reg == '0))
        else $error("parser not idle after frame end");

endmodule
